[hw/rtl/vcpdc_pkg.sv]
// Types, codes and helper functions shared by the display check block.
// No dependencies.
`default_nettype none
package vcpdc_pkg;

	// Configuration register indices
	localparam logic [2:0] REG_CYCLE_A0    = 3'd0;
	localparam logic [2:0] REG_CYCLE_A1    = 3'd1;
	localparam logic [2:0] REG_CYCLE_B0    = 3'd2;
	localparam logic [2:0] REG_CYCLE_B1    = 3'd3;
	localparam logic [2:0] REG_VRAM_MODE   = 3'd4;
	localparam logic [2:0] REG_SCREEN_EN   = 3'd5;
	localparam logic [2:0] REG_CHAR_CTRL   = 3'd6;
	localparam logic [2:0] REG_ZOOM_CTRL   = 3'd7;

	// Screen codes
	localparam logic [2:0] SCR_NBG0 = 3'd0;
	localparam logic [2:0] SCR_NBG1 = 3'd1;
	localparam logic [2:0] SCR_NBG2 = 3'd2;
	localparam logic [2:0] SCR_NBG3 = 3'd3;
	localparam logic [2:0] SCR_RBG0 = 3'd4;
	localparam logic [2:0] SCR_RBG1 = 3'd5;

	// Colour depth codes
	localparam logic [2:0] COL_16    = 3'd0;
	localparam logic [2:0] COL_256   = 3'd1;
	localparam logic [2:0] COL_2048  = 3'd2;
	localparam logic [2:0] COL_32K   = 3'd3;
	localparam logic [2:0] COL_16M   = 3'd4;

	// Offset from a name-read command to the character-read command
	localparam logic [3:0] CMD_CHAR_BASE = 4'd4;

	typedef enum logic [1:0] {
		RED_NONE,
		RED_HALF,
		RED_QUARTER
	} red_t;

	typedef struct packed {
		logic [31:0] cycle_a0;
		logic [31:0] cycle_a1;
		logic [31:0] cycle_b0;
		logic [31:0] cycle_b1;
		logic [2:0]  vram_mode;
		logic [5:0]  screen_enable;
		logic [8:0]  char_control;
		logic [3:0]  zoom_control;
	} cfg_t;

	typedef struct packed {
		logic [5:0] available_char_reads;
		logic [3:0] required_char_reads;
		logic [4:0] available_name_reads;
		logic [2:0] required_name_reads;
		logic       displayed;
	} res_t;

	function automatic red_t reduction_of(input logic half, input logic quarter);
		red_t r;
		if (quarter)
			r = RED_QUARTER;
		else if (half)
			r = RED_HALF;
		else
			r = RED_NONE;
		return r;
	endfunction

	function automatic logic [3:0] count_slots(input logic [31:0] bank,
		input logic [3:0] cmd, input logic [7:0] slot_mask);
		logic [3:0] n;
		n = 4'd0;
		for (int k = 0; k < 8; k++) begin
			if (slot_mask[k] && bank[4*k +: 4] == cmd)
				n = n + 4'd1;
		end
		return n;
	endfunction

	function automatic logic [2:0] name_req(input red_t red);
		logic [2:0] r;
		case (red)
			RED_QUARTER: r = 3'd4;
			RED_HALF:    r = 3'd2;
			default:     r = 3'd1;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] char_req(input red_t red, input logic [2:0] colour);
		logic [3:0] r;
		case (colour)
			COL_16: begin
				case (red)
					RED_QUARTER: r = 4'd4;
					RED_HALF:    r = 4'd2;
					default:     r = 4'd1;
				endcase
			end
			COL_256: begin
				case (red)
					RED_QUARTER: r = 4'd0;
					RED_HALF:    r = 4'd4;
					default:     r = 4'd2;
				endcase
			end
			COL_2048, COL_32K: r = (red == RED_NONE) ? 4'd4 : 4'd0;
			COL_16M:           r = (red == RED_NONE) ? 4'd8 : 4'd0;
			default:           r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic limited_by(input red_t red, input logic [2:0] colour);
		return (red == RED_QUARTER && colour == COL_16) ||
			(red == RED_HALF && colour == COL_256);
	endfunction

endpackage
`default_nettype wire

[hw/rtl/vcpdc_cfg_regs.sv]
// Configuration register file for the display check block.
// Depends on vcpdc_pkg.
`default_nettype none
module vcpdc_cfg_regs
	import vcpdc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cycle_a0      <= 32'hFFFF_FFFF;
			cfg_q.cycle_a1      <= 32'hFFFF_FFFF;
			cfg_q.cycle_b0      <= 32'hFFFF_FFFF;
			cfg_q.cycle_b1      <= 32'hFFFF_FFFF;
			cfg_q.vram_mode     <= 3'd4;
			cfg_q.screen_enable <= 6'd0;
			cfg_q.char_control  <= 9'd0;
			cfg_q.zoom_control  <= 4'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CYCLE_A0:  cfg_q.cycle_a0      <= cfg_wdata;
				REG_CYCLE_A1:  cfg_q.cycle_a1      <= cfg_wdata;
				REG_CYCLE_B0:  cfg_q.cycle_b0      <= cfg_wdata;
				REG_CYCLE_B1:  cfg_q.cycle_b1      <= cfg_wdata;
				REG_VRAM_MODE: cfg_q.vram_mode     <= cfg_wdata[2:0];
				REG_SCREEN_EN: cfg_q.screen_enable <= cfg_wdata[5:0];
				REG_CHAR_CTRL: cfg_q.char_control  <= cfg_wdata[8:0];
				REG_ZOOM_CTRL: cfg_q.zoom_control  <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[hw/rtl/vcpdc_eval.sv]
// Combinational read counting and display decision for one screen query.
// Depends on vcpdc_pkg.
`default_nettype none
module vcpdc_eval
	import vcpdc_pkg::*;
(
	input  wire cfg_t        cfg,
	input  wire logic [7:0]  slot_mask,
	input  wire logic [2:0]  screen,
	output res_t             res
);

	red_t       red0, red1, red;
	logic [2:0] col0, col1, colour;
	logic       bitmap, ok, en;
	logic [3:0] name_cmd, char_cmd;
	logic [3:0] a0n, a1n, b0n, b1n, a0c, a1c, b0c, b1c;
	logic [4:0] sum0, sum1, an;
	logic [5:0] ac;
	logic [2:0] rn;
	logic [3:0] rc;

	assign red0 = reduction_of(cfg.zoom_control[0], cfg.zoom_control[1]);
	assign red1 = reduction_of(cfg.zoom_control[2], cfg.zoom_control[3]);
	assign col0 = cfg.char_control[3:1];
	assign col1 = {1'b0, cfg.char_control[6:5]};

	assign name_cmd = {2'b00, screen[1:0]};
	assign char_cmd = CMD_CHAR_BASE + name_cmd;

	assign a0n = count_slots(cfg.cycle_a0, name_cmd, slot_mask);
	assign a1n = count_slots(cfg.cycle_a1, name_cmd, slot_mask);
	assign b0n = count_slots(cfg.cycle_b0, name_cmd, slot_mask);
	assign b1n = count_slots(cfg.cycle_b1, name_cmd, slot_mask);
	assign a0c = count_slots(cfg.cycle_a0, char_cmd, slot_mask);
	assign a1c = count_slots(cfg.cycle_a1, char_cmd, slot_mask);
	assign b0c = count_slots(cfg.cycle_b0, char_cmd, slot_mask);
	assign b1c = count_slots(cfg.cycle_b1, char_cmd, slot_mask);

	assign sum0 = {1'b0, a0n} + {1'b0, b0n};
	assign sum1 = {1'b0, a1n} + {1'b0, b1n};

	always_comb begin
		red    = RED_NONE;
		colour = COL_16;
		bitmap = 1'b0;
		ok     = 1'b1;
		rn     = 3'd0;
		an     = 5'd0;
		rc     = 4'd0;
		ac     = 6'd0;
		en     = cfg.screen_enable[screen[1:0]];
		case (screen)
			SCR_NBG0: begin
				red    = red0;
				colour = col0;
				bitmap = cfg.char_control[0];
			end
			SCR_NBG1: begin
				red    = red1;
				colour = col1;
				bitmap = cfg.char_control[4];
			end
			SCR_NBG2: begin
				colour = {2'b00, cfg.char_control[7]};
				ok     = !limited_by(red0, col0);
			end
			SCR_NBG3: begin
				colour = {2'b00, cfg.char_control[8]};
				ok     = !limited_by(red1, col1);
			end
			default: ;
		endcase
		if (screen[2] == 1'b0) begin
			rc = char_req(red, colour);
			if (bitmap) begin
				ac = {2'b00, a0c} + {2'b00, b0c}
					+ (cfg.vram_mode[0] ? {2'b00, a1c} : 6'd0)
					+ (cfg.vram_mode[1] ? {2'b00, b1c} : 6'd0);
			end else begin
				rn = name_req(red);
				an = (cfg.vram_mode[1:0] == 2'b11 && sum1 > sum0) ? sum1 : sum0;
				ac = {2'b00, a0c} + {2'b00, b0c} + {2'b00, a1c} + {2'b00, b1c};
				if (an < {2'b00, rn})
					ok = 1'b0;
			end
			if (ac < {2'b00, rc})
				ok = 1'b0;
			res.displayed = en && ok;
		end else if (screen == SCR_RBG0 || screen == SCR_RBG1) begin
			res.displayed = cfg.screen_enable[{1'b0, screen[0]} + 3'd4];
		end else begin
			res.displayed = 1'b0;
		end
		res.required_name_reads  = rn;
		res.available_name_reads = an;
		res.required_char_reads  = rc;
		res.available_char_reads = ac;
	end

endmodule
`default_nettype wire

[hw/rtl/vram_cycle_pattern_display_check_core.sv]
// Top level of the background screen display check against VRAM cycle patterns.
// Depends on vcpdc_pkg, vcpdc_cfg_regs and vcpdc_eval.
//
// Usage:
//   Registers are written through cfg_we / cfg_index / cfg_wdata, one per
//   clock; the user must do so only while no query is in flight, as the block
//   does not enforce this. A query beat on s_* carries the screen code; each
//   one yields exactly one result beat on m_* with the display flag and the
//   read counts. The beat is registered in the input stage and evaluated into
//   the output register, which drives m_tvalid and m_tdata.
//   Throughput: one query per clock while m_tready is high; the input stage
//   and the output register together form a two-deep pipeline that keeps
//   taking beats while a result waits, as long as a stage is free.
//   When m_tready is low the result holds and s_tready drops once both stages
//   are full.
//   Reset: both stages empty, registers at their reset values (all banks no
//   access, normal resolution, all screens disabled).
//   SLOTS_PER_BANK (4..8) sets how many slots count in normal resolution.
`default_nettype none
module vram_cycle_pattern_display_check_core
	import vcpdc_pkg::*;
#(
	parameter int SLOTS_PER_BANK = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [2:0] screen, [7:3] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata    // [0] displayed, [3:1] required_name_reads,
	                                    // [8:4] available_name_reads,
	                                    // [12:9] required_char_reads,
	                                    // [18:13] available_char_reads, [23:19] zero
);

	cfg_t       cfg;
	logic [7:0] slot_mask;
	logic       valid_s1, valid_s2, ready_s1;
	logic [2:0] screen_s1;
	res_t       res, res_s2;

	vcpdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	always_comb begin
		for (int k = 0; k < 8; k++)
			slot_mask[k] = (k < 4) || (cfg.vram_mode[2] && k < SLOTS_PER_BANK);
	end

	assign ready_s1 = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (ready_s1)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			screen_s1 <= s_tdata[2:0];
		if (valid_s1 && ready_s1)
			res_s2 <= res;
	end

	vcpdc_eval u_eval (
		.cfg       (cfg),
		.slot_mask (slot_mask),
		.screen    (screen_s1),
		.res       (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, res_s2};

	// an accepted beat occupies the input stage next cycle
	a_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted beat lost at input stage");

	// a beat leaving the input stage becomes a result
	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ready_s1) |=> m_tvalid)
		else $error("evaluated beat lost at output stage");

	// a shown screen never lacks character reads
	a_char_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.displayed) |->
		(res_s2.available_char_reads >= {2'b00, res_s2.required_char_reads}))
		else $error("displayed with too few character reads");

endmodule
`default_nettype wire
